FILE: rtl/core/graph_one_hop_neighbor_set_unit_macros.svh
// Assertion macros shared by the one-hop neighbor set unit RTL.
`ifndef GRAPH_ONE_HOP_NEIGHBOR_SET_UNIT_MACROS_SVH
`define GRAPH_ONE_HOP_NEIGHBOR_SET_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GOHS_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gohs: same-cycle check failed");
`define GOHS_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gohs: next-cycle check failed");
`else
`define GOHS_IMP(lbl, clk, rst, ante, cons)
`define GOHS_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/gohs_pkg.sv
// Shared types and constants of the one-hop neighbor set unit.
package gohs_pkg;

  localparam int ID_W = 6;

  typedef enum logic [1:0] {
    ST_NEIGHBOR = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_STORED   = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  typedef struct packed {
    logic            mark;
    logic [ID_W-1:0] mark_id;
    logic            scan;
    logic            out_free;
  } vis_ctl_t;

  typedef struct packed {
    logic            fire;
    status_t         status;
    logic [ID_W-1:0] id;
    logic            last;
    logic            busy;
  } vis_word_t;

endpackage

FILE: rtl/core/gohs_scan.sv
// Visited map memory with mark port and ascending-order result scanner.
`include "graph_one_hop_neighbor_set_unit_macros.svh"

module gohs_scan #(
  parameter int NODES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  gohs_pkg::vis_ctl_t  ctl,
  output gohs_pkg::vis_word_t word
);
  import gohs_pkg::*;

  localparam int NW = $clog2(NODES);

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_RUN, S_FIN} state_t;

  state_t        state;
  logic [NW-1:0] idx;
  logic [NW-1:0] held;
  logic          held_vld;
  logic          vis_mem [NODES];
  logic          rd_bit;
  logic          rd_en;
  logic          wr_en;
  logic          wr_bit;
  logic [NW-1:0] rd_addr;
  logic [NW-1:0] wr_addr;
  logic          idx_last;
  logic          step;

  assign idx_last = (idx == NW'(NODES - 1));
  assign step     = (state == S_RUN) && (!(rd_bit && held_vld) || ctl.out_free);

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_bit  = 1'b0;
    rd_addr = idx;
    wr_addr = idx;
    case (state)
      S_CLR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        if (ctl.scan) begin
          rd_en   = 1'b1;
          wr_en   = 1'b1;
          rd_addr = '0;
          wr_addr = '0;
        end else if (ctl.mark) begin
          wr_en   = 1'b1;
          wr_bit  = 1'b1;
          wr_addr = ctl.mark_id[NW-1:0];
        end
      end
      S_RUN: begin
        if (step && !idx_last) begin
          rd_en   = 1'b1;
          wr_en   = 1'b1;
          rd_addr = idx + NW'(1);
          wr_addr = idx + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    word.busy   = (state != S_IDLE);
    word.fire   = 1'b0;
    word.status = ST_NEIGHBOR;
    word.id     = ID_W'(held);
    word.last   = 1'b0;
    case (state)
      S_RUN: begin
        word.fire = step && rd_bit && held_vld;
      end
      S_FIN: begin
        word.fire = ctl.out_free;
        word.last = 1'b1;
        if (!held_vld) begin
          word.status = ST_EMPTY;
          word.id     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vis_mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit <= vis_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      idx      <= '0;
      held_vld <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          idx <= idx + NW'(1);
          if (idx_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (ctl.scan) begin
            idx      <= '0;
            held_vld <= 1'b0;
            state    <= S_RUN;
          end
        end
        S_RUN: begin
          if (step) begin
            if (rd_bit) begin
              held     <= idx;
              held_vld <= 1'b1;
            end
            if (idx_last) begin
              state <= S_FIN;
            end else begin
              idx <= idx + NW'(1);
            end
          end
        end
        S_FIN: begin
          if (ctl.out_free) begin
            held_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GOHS_IMP(a_mark_idle, clk, rst, ctl.mark, state == S_IDLE)
  `GOHS_IMP(a_mid_neighbor, clk, rst, word.fire && !word.last, word.status == ST_NEIGHBOR)
  `GOHS_NXT(a_fin_done, clk, rst, word.fire && word.last, state == S_IDLE && !held_vld)

endmodule

FILE: rtl/core/graph_one_hop_neighbor_set_unit.sv
// Top level of the one-hop neighbor set unit: edge table, counts and control.
//
// Input channel (in_valid / in_stall) carries one word per item: func selects
// add-edge (0) or query seed (1); node_id, dest_id and last_seed complete it.
// Output channel (out_valid / out_stall) carries status, neighbor_id and last.
// Add edge: one word (stored or dropped) is registered from the count state
// once the output register is free; the unit then takes the next item.
// Seed: the count memory is read on accept, then the seed's stored edges are
// walked one per cycle through the edge memory. The final seed then scans the
// visited memory, one node per cycle except while the output stalls (capped
// at 64 nodes), giving each marked node in ascending order, or one empty word
// when none is marked. Seeds between queries keep their marks; an edge added
// meanwhile is stored unless the node's edge count is full.
// A stall on the output holds the output register and pauses the scan or the
// edge result; in_stall stays high until the pending work can move on.
// After reset both the count memory and the visited memory are cleared, one
// entry per cycle; in_stall is high meanwhile.
`include "graph_one_hop_neighbor_set_unit_macros.svh"

module graph_one_hop_neighbor_set_unit #(
  parameter int NODE_COUNT = 64,
  parameter int MAX_DEGREE = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      func,
  input  logic [gohs_pkg::ID_W-1:0] node_id,
  input  logic [gohs_pkg::ID_W-1:0] dest_id,
  input  logic                      last_seed,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [gohs_pkg::ID_W-1:0] neighbor_id,
  output logic                      last
);
  import gohs_pkg::*;

  localparam int IdRange = 1 << ID_W;
  localparam int NODES   = (NODE_COUNT < IdRange) ? NODE_COUNT : IdRange;
  localparam int NW      = $clog2(NODES);
  localparam int CW      = $clog2(MAX_DEGREE + 1);
  localparam int SW      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int EDGES   = NODES * MAX_DEGREE;
  localparam int AW      = $clog2(EDGES);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_CNT, S_WALK, S_SCAN} state_t;

  state_t        state;
  logic [NW-1:0] clr_idx;
  logic          func_q;
  logic [NW-1:0] node_q;
  logic [NW-1:0] target_q;
  logic          last_q;
  logic [SW-1:0] slot;

  logic          o_vld;
  status_t       o_status;
  logic [ID_W-1:0] o_id;
  logic          o_last;

  logic [NW-1:0] narrow_tab [IdRange];
  logic [NW-1:0] node_n;
  logic [NW-1:0] target_n;

  logic [CW-1:0] cnt_mem [NODES];
  logic [CW-1:0] cnt_rd;
  logic          cnt_we;
  logic [NW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  logic [NW-1:0] edge_mem [EDGES];
  logic [NW-1:0] edge_rd;
  logic          edge_we;
  logic          edge_re;
  logic [SW-1:0] e_slot;
  logic [AW-1:0] e_base;
  logic [AW-1:0] e_addr;

  logic          accept;
  logic          out_free;
  logic          edge_fire;
  logic          cnt_full;
  logic          walk_more;

  vis_ctl_t      ctl;
  vis_word_t     vw;

  for (genvar g = 0; g < IdRange; g++) begin : g_narrow
    assign narrow_tab[g] = NW'(g % NODES);
  end

  assign node_n   = narrow_tab[node_id];
  assign target_n = narrow_tab[dest_id];

  assign in_stall  = (state != S_IDLE) || vw.busy;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !o_vld || !out_stall;
  assign cnt_full  = (cnt_rd == CW'(MAX_DEGREE));
  assign edge_fire = (state == S_CNT) && !func_q && out_free;
  assign walk_more = ((CW'(slot) + CW'(1)) < cnt_rd);

  assign e_base = AW'(node_q) * AW'(MAX_DEGREE);
  assign e_addr = e_base + AW'(e_slot);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = node_q;
    cnt_wdata = cnt_rd + CW'(1);
    edge_we   = 1'b0;
    edge_re   = 1'b0;
    e_slot    = '0;
    case (state)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx;
        cnt_wdata = '0;
      end
      S_CNT: begin
        if (func_q) begin
          edge_re = (cnt_rd != '0);
        end else begin
          cnt_we  = edge_fire && !cnt_full;
          edge_we = edge_fire && !cnt_full;
          e_slot  = SW'(cnt_rd);
        end
      end
      S_WALK: begin
        edge_re = walk_more;
        e_slot  = slot + SW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.mark     = (state == S_WALK);
    ctl.mark_id  = ID_W'(edge_rd);
    ctl.scan     = (state == S_SCAN);
    ctl.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (accept) begin
      cnt_rd <= cnt_mem[node_n];
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[e_addr] <= target_q;
    end
    if (edge_re) begin
      edge_rd <= edge_mem[e_addr];
    end
  end

  gohs_scan #(
    .NODES (NODES)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .word (vw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      o_vld   <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == NW'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_q   <= func;
            node_q   <= node_n;
            target_q <= target_n;
            last_q   <= last_seed;
            state    <= S_CNT;
          end
        end
        S_CNT: begin
          if (!func_q) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else if (cnt_rd != '0) begin
            slot  <= '0;
            state <= S_WALK;
          end else begin
            state <= last_q ? S_SCAN : S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_more) begin
            slot <= slot + SW'(1);
          end else begin
            state <= last_q ? S_SCAN : S_IDLE;
          end
        end
        S_SCAN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (vw.fire) begin
        o_vld    <= 1'b1;
        o_status <= vw.status;
        o_id     <= vw.id;
        o_last   <= vw.last;
      end else if (edge_fire) begin
        o_vld    <= 1'b1;
        o_status <= cnt_full ? ST_DROPPED : ST_STORED;
        o_id     <= '0;
        o_last   <= 1'b1;
      end else if (!out_stall) begin
        o_vld <= 1'b0;
      end
    end
  end

  assign out_valid   = o_vld;
  assign status      = o_status;
  assign neighbor_id = o_id;
  assign last        = o_last;

  `GOHS_IMP(a_one_source, clk, rst, vw.fire, !edge_fire)
  `GOHS_IMP(a_cnt_bound, clk, rst, cnt_we, cnt_wdata <= CW'(MAX_DEGREE))
  `GOHS_NXT(a_walk_mark, clk, rst, state == S_CNT && func_q && cnt_rd != '0, ctl.mark)

endmodule
